### sv/llwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llwd_pkg: shared types and constants of the least-loaded worker dispatcher
// Holds event and status codes, the worker table size, the reset worker count,
// and the command and status bundles exchanged between the controller and the
// datapath.
// ----------------------------------------------------------------------------
package llwd_pkg;

	localparam logic ACT_DISPATCH = 1'b0;
	localparam logic ACT_SERVED   = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SAT     = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam int MAX_WORKERS      = 16;
	localparam int WORKER_COUNT_RST = 16;

	typedef struct packed {
		logic load;
		logic issue;
		logic cmp;
		logic commit;
	} llwd_cmd_t;

	typedef struct packed {
		logic action;
		logic scan_last;
		logic out_free;
	} llwd_stat_t;

endpackage

### sv/llwd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llwd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module llwd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/llwd_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llwd_dpath: datapath of the least-loaded worker dispatcher
// Holds the active worker count, the event registers, the scan pointer, the
// running minimum, the pending-count RAM with its valid bits and the result
// register.
// ----------------------------------------------------------------------------
module llwd_dpath #(
	parameter int COUNT_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  llwd_pkg::llwd_cmd_t  cmd,
	output llwd_pkg::llwd_stat_t stat,
	input  logic                 cfg_we,
	input  logic [4:0]           cfg_worker_count,
	input  logic                 in_action,
	input  logic [15:0]          in_handle,
	input  logic [3:0]           in_start,
	input  logic [3:0]           in_served,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3:0]           out_chosen,
	output logic [15:0]          out_handle,
	output logic [15:0]          out_after,
	output logic [1:0]           out_status
);

	localparam int MAX_WORKERS = llwd_pkg::MAX_WORKERS;
	localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int NW = $clog2(MAX_WORKERS + 1);
	localparam int RST_N = (llwd_pkg::WORKER_COUNT_RST > MAX_WORKERS) ?
		MAX_WORKERS : llwd_pkg::WORKER_COUNT_RST;
	localparam logic [COUNT_BITS-1:0] LIMIT = {COUNT_BITS{1'b1}};

	logic [NW-1:0]         n_q;
	logic                  action_q;
	logic [15:0]           handle_q;
	logic [3:0]            served_q;
	logic                  srv_bad_q;
	logic [IW-1:0]         scan_idx_q;
	logic [NW-1:0]         scan_cnt_q;
	logic                  rd_first_q;
	logic [IW-1:0]         rd_pos_q;
	logic                  rdv_q;
	logic [COUNT_BITS-1:0] best_q;
	logic [IW-1:0]         best_pos_q;
	logic [MAX_WORKERS-1:0] valid_q;
	logic                  out_valid_q;
	logic [3:0]            chosen_q;
	logic [15:0]           hout_q;
	logic [15:0]           after_q;
	logic [1:0]            status_q;

	logic [IW-1:0]         rd_addr;
	logic [COUNT_BITS-1:0] rd_data;
	logic [COUNT_BITS-1:0] rd_val;
	logic [31:0]           cfg_n;
	logic [31:0]           idx_next;
	logic [IW-1:0]         wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  wr_en;
	logic [1:0]            st_new;
	logic [COUNT_BITS-1:0] after_new;
	logic                  start_bad;
	logic                  served_bad;

	assign start_bad  = 32'(in_start) >= 32'(n_q);
	assign served_bad = 32'(in_served) >= 32'(n_q);
	assign rd_addr    = action_q ? IW'(32'(served_q)) : scan_idx_q;
	assign rd_val     = rdv_q ? rd_data : '0;
	assign idx_next   = 32'(scan_idx_q) + 32'd1;

	always_comb begin
		cfg_n = 32'(cfg_worker_count);
		if (cfg_n == 32'd0) begin
			cfg_n = 32'd1;
		end else if (cfg_n > 32'(MAX_WORKERS)) begin
			cfg_n = 32'(MAX_WORKERS);
		end
	end

	always_comb begin
		wr_addr   = best_pos_q;
		wr_data   = best_q;
		wr_en     = 1'b0;
		st_new    = llwd_pkg::ST_OK;
		after_new = best_q;
		if (action_q == llwd_pkg::ACT_DISPATCH) begin
			if (best_q == LIMIT) begin
				st_new = llwd_pkg::ST_SAT;
			end else begin
				after_new = best_q + COUNT_BITS'(1);
				wr_data   = after_new;
				wr_en     = cmd.commit;
			end
		end else begin
			wr_addr = IW'(32'(served_q));
			if (srv_bad_q || best_q == '0) begin
				st_new    = llwd_pkg::ST_INVALID;
				after_new = '0;
			end else begin
				after_new = best_q - COUNT_BITS'(1);
				wr_data   = after_new;
				wr_en     = cmd.commit;
			end
		end
	end

	llwd_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MAX_WORKERS)
	) u_count_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (cmd.issue),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= NW'(RST_N);
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				n_q <= NW'(cfg_n);
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q   <= in_action;
			handle_q   <= in_handle;
			served_q   <= in_served;
			srv_bad_q  <= served_bad;
			scan_idx_q <= start_bad ? '0 : IW'(32'(in_start));
			scan_cnt_q <= '0;
		end
		if (cmd.issue) begin
			scan_idx_q <= (idx_next >= 32'(n_q)) ? '0 : IW'(idx_next);
			scan_cnt_q <= scan_cnt_q + NW'(1);
			rd_first_q <= action_q || scan_cnt_q == '0;
			rd_pos_q   <= rd_addr;
			rdv_q      <= valid_q[rd_addr];
		end
		if (cmd.cmp && (rd_first_q || rd_val < best_q)) begin
			best_q     <= rd_val;
			best_pos_q <= rd_pos_q;
		end
		if (cmd.commit) begin
			chosen_q <= action_q ? served_q : 4'(best_pos_q);
			hout_q   <= action_q ? 16'd0 : handle_q;
			after_q  <= 16'(32'(after_new));
			status_q <= st_new;
		end
	end

	assign stat.action    = action_q;
	assign stat.scan_last = 32'(scan_cnt_q) == 32'(n_q) - 32'd1;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_chosen = chosen_q;
	assign out_handle = hout_q;
	assign out_after  = after_q;
	assign out_status = status_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		n_q != '0 && 32'(n_q) <= 32'(MAX_WORKERS))
		else $error("Active worker count left its legal range.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && !action_q |-> 32'(scan_cnt_q) < 32'(n_q))
		else $error("Scan read more workers than are active.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("Committed result did not reach the output register.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == llwd_pkg::ST_INVALID |-> after_q == 16'd0)
		else $error("Ignored served event reported a nonzero count.");

endmodule

### sv/llwd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llwd_ctrl: controller of the least-loaded worker dispatcher
// Sequences event acceptance, the cyclic scan of pending counts, the final
// compare and the update and result write-back.
// ----------------------------------------------------------------------------
module llwd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  llwd_pkg::llwd_stat_t stat,
	output llwd_pkg::llwd_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_SRV    = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       cmp_pend_q;

	assign in_ready   = state_q == S_IDLE;
	assign cmd.load   = in_ready && in_valid;
	assign cmd.issue  = state_q == S_SCAN || state_q == S_SRV;
	assign cmd.cmp    = cmp_pend_q;
	assign cmd.commit = state_q == S_COMMIT && stat.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (stat.action == llwd_pkg::ACT_SERVED) ? S_SRV : S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_SRV: begin
				state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmp_pend_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_pend_q <= cmd.issue;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |=> state_q == S_COMMIT)
		else $error("Final compare was not followed by the update.");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |-> cmp_pend_q)
		else $error("Final compare ran without a read in flight.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == S_IDLE)
		else $error("Controller did not return to idle after the update.");

endmodule

### sv/least_loaded_worker_dispatch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_worker_dispatch: join-shortest-queue dispatcher
// Keeps a pending-job count per worker. Dispatch events pick the first worker
// with the smallest count in a cyclic scan and increment it unless saturated;
// served events decrement the named active worker's count unless it is zero.
//
// Channel   Direction  Transaction         Contents
// s_axis    in         event               tdata, tuser = action
// m_axis    out        result              tdata, tuser = status
// cfg       in         register write      cfg_data = worker_count
//
// A dispatch makes one registered RAM read per active worker, then a final
// compare and the update. A served event makes a single read of the named
// worker's count, then the final compare and the update. The controller
// returns to idle after the update before it accepts the next event.
// One event is in work at a time.
// Reset sets worker_count to 16 and all counts to zero via per-entry valid
// bits, with no clearing pass. A stalled result holds the update step; a new
// event may be accepted while a result waits in the output register.
// ----------------------------------------------------------------------------
module least_loaded_worker_dispatch #(
	parameter int COUNT_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] client_handle, [19:16] start_offset, [23:20] served_worker
	input  logic [23:0] s_tdata,
	// [0] action
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] chosen_worker, [19:4] handle_out, [35:20] pending_after, [39:36] zero
	output logic [39:0] m_tdata,
	// [1:0] status
	output logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	llwd_pkg::llwd_cmd_t  cmd;
	llwd_pkg::llwd_stat_t stat;
	llwd_pkg::llwd_stat_t dp_stat;
	logic [3:0]           chosen;
	logic [15:0]          hout;
	logic [15:0]          after;

	assign cfg_ready = 1'b1;

	always_comb begin
		stat = dp_stat;
		if (s_tready) begin
			stat.action = s_tuser[0];
		end
	end

	llwd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	llwd_dpath #(
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (dp_stat),
		.cfg_we          (cfg_valid),
		.cfg_worker_count(cfg_data),
		.in_action       (s_tuser[0]),
		.in_handle       (s_tdata[15:0]),
		.in_start        (s_tdata[19:16]),
		.in_served       (s_tdata[23:20]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_chosen      (chosen),
		.out_handle      (hout),
		.out_after       (after),
		.out_status      (m_tuser)
	);

	assign m_tdata = {4'd0, after, hout, chosen};

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the least-loaded worker dispatcher
// Events are generated into a queue and streamed in under random gaps and
// back-pressure. A behavioral copy of the pending-count table predicts each
// result, and every result transaction is compared field by field. The run
// covers several worker counts, including zero and values above the maximum,
// and a single worker that takes a long run of dispatches.
// ----------------------------------------------------------------------------
module tb;

	localparam int          NUM_WORKERS = llwd_pkg::MAX_WORKERS;
	localparam int          IDLE_LIMIT  = 4000;
	localparam int          TAIL_CYCLES = 24;
	localparam int          LONG_HOLD   = 400;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

	typedef struct packed {
		logic        action;
		logic [3:0]  served_worker;
		logic [3:0]  start_offset;
		logic [15:0] client_handle;
	} job_event_t;

	typedef struct packed {
		logic [3:0]  chosen_worker;
		logic [15:0] handle_out;
		logic [15:0] pending_after;
		logic [1:0]  status;
	} dispatch_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic [0:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data  = '0;

	job_event_t       job_q[$];
	dispatch_result_t expected_q[$];
	logic [15:0]      load_tab [NUM_WORKERS];
	logic [4:0]       worker_setting = 5'(llwd_pkg::WORKER_COUNT_RST);

	int unsigned n_queued      = 0;
	int unsigned n_taken       = 0;
	int unsigned n_checked     = 0;
	int unsigned n_errors      = 0;
	int unsigned idle_cycles   = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_left     = 0;
	bit          hold_req      = 1'b0;
	bit          s_fire        = 1'b0;

	least_loaded_worker_dispatch u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned active_count();
		if (worker_setting == 0)
			return 1;
		if (worker_setting > NUM_WORKERS)
			return NUM_WORKERS;
		return 32'(worker_setting);
	endfunction

	// Applies one event to the count table and returns the result it yields.
	function automatic dispatch_result_t jsq_step(job_event_t ev);
		int unsigned n;
		int unsigned pick;
		int unsigned idx;
		dispatch_result_t r;
		n = active_count();
		r = '0;
		r.status = llwd_pkg::ST_OK;
		if (ev.action == llwd_pkg::ACT_DISPATCH) begin
			pick = (32'(ev.start_offset) >= n) ? 0 : 32'(ev.start_offset);
			idx = pick;
			for (int k = 0; k < n; k++) begin
				if (load_tab[idx] < load_tab[pick])
					pick = idx;
				idx = (idx + 1 >= n) ? 0 : idx + 1;
			end
			if (load_tab[pick] == COUNT_MAX)
				r.status = llwd_pkg::ST_SAT;
			else
				load_tab[pick] = load_tab[pick] + 16'd1;
			r.chosen_worker = pick[3:0];
			r.handle_out    = ev.client_handle;
			r.pending_after = load_tab[pick];
		end else begin
			r.chosen_worker = ev.served_worker;
			if (32'(ev.served_worker) >= n || load_tab[ev.served_worker] == '0) begin
				r.status = llwd_pkg::ST_INVALID;
			end else begin
				load_tab[ev.served_worker] = load_tab[ev.served_worker] - 16'd1;
				r.pending_after = load_tab[ev.served_worker];
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(string field, logic [15:0] got, logic [15:0] want);
		if (n_errors < 100)
			$display("[%0t] %s: got %h, expected %h", $time, field, got, want);
		n_errors++;
	endtask

	task automatic add_event(logic action, logic [15:0] handle, logic [3:0] start,
			logic [3:0] served);
		job_event_t ev;
		ev.action        = action;
		ev.client_handle = handle;
		ev.start_offset  = start;
		ev.served_worker = served;
		job_q.push_back(ev);
		n_queued++;
	endtask

	// Served events mostly name an active worker so that counts move both ways.
	task automatic add_random(int unsigned count);
		int unsigned n;
		job_event_t ev;
		n = active_count();
		repeat (count) begin
			ev.action        = ($urandom_range(99) < 40) ? llwd_pkg::ACT_SERVED :
				llwd_pkg::ACT_DISPATCH;
			ev.client_handle = 16'($urandom);
			ev.start_offset  = 4'($urandom);
			if ($urandom_range(4) == 0)
				ev.served_worker = 4'($urandom);
			else
				ev.served_worker = 4'($urandom_range(n - 1));
			job_q.push_back(ev);
		end
		n_queued += count;
	endtask

	task automatic settle();
		wait (n_taken == n_queued && n_checked == n_taken);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic set_workers(logic [4:0] value);
		settle();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		job_event_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_fire) begin
			if (job_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = job_q.pop_front();
				s_tdata  <= {nxt.served_worker, nxt.start_offset, nxt.client_handle};
				s_tuser  <= nxt.action;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		dispatch_result_t got;
		dispatch_result_t want;
		job_event_t ev;
		if (arst_n) begin
			s_fire <= s_tvalid && s_tready;
			if (cfg_valid && cfg_ready)
				worker_setting = cfg_data;
			if (m_tvalid && m_tready) begin
				got.chosen_worker = m_tdata[3:0];
				got.handle_out    = m_tdata[19:4];
				got.pending_after = m_tdata[35:20];
				got.status        = m_tuser;
				if (expected_q.size() == 0) begin
					flag_mismatch("result without a pending event",
						16'(got.chosen_worker), 16'd0);
				end else begin
					want = expected_q.pop_front();
					n_checked++;
					if (got.chosen_worker !== want.chosen_worker)
						flag_mismatch("chosen_worker", 16'(got.chosen_worker),
							16'(want.chosen_worker));
					if (got.handle_out !== want.handle_out)
						flag_mismatch("handle_out", got.handle_out, want.handle_out);
					if (got.pending_after !== want.pending_after)
						flag_mismatch("pending_after", got.pending_after, want.pending_after);
					if (got.status !== want.status)
						flag_mismatch("status", 16'(got.status), 16'(want.status));
				end
			end
			if (s_tvalid && s_tready) begin
				ev.action        = s_tuser[0];
				ev.client_handle = s_tdata[15:0];
				ev.start_offset  = s_tdata[19:16];
				ev.served_worker = s_tdata[23:20];
				expected_q.push_back(jsq_step(ev));
				n_taken++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles++;
			end
		end
	end

	initial begin
		foreach (load_tab[i])
			load_tab[i] = '0;
		send_idle_pct = 31;
		recv_idle_pct = 80;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// All sixteen workers active after reset; ties, wrap-around and zero counts.
		add_event(llwd_pkg::ACT_DISPATCH, 16'h0000, 4'd0,  4'd0);
		add_event(llwd_pkg::ACT_DISPATCH, 16'hFFFF, 4'd15, 4'd15);
		add_event(llwd_pkg::ACT_DISPATCH, 16'h5A5A, 4'd0,  4'd9);
		add_event(llwd_pkg::ACT_SERVED,   16'hFFFF, 4'd15, 4'd0);
		add_event(llwd_pkg::ACT_SERVED,   16'h0000, 4'd0,  4'd0);
		add_event(llwd_pkg::ACT_SERVED,   16'hA5A5, 4'd7,  4'd15);
		add_event(llwd_pkg::ACT_SERVED,   16'h0001, 4'd3,  4'd15);
		add_event(llwd_pkg::ACT_DISPATCH, 16'h1234, 4'd8,  4'd0);
		add_event(llwd_pkg::ACT_DISPATCH, 16'hABCD, 4'd7,  4'd0);
		add_event(llwd_pkg::ACT_SERVED,   16'h0000, 4'd0,  4'd1);
		add_event(llwd_pkg::ACT_DISPATCH, 16'h8000, 4'd15, 4'd0);
		add_event(llwd_pkg::ACT_DISPATCH, 16'h7FFF, 4'd15, 4'd0);

		// Four active workers: offsets and served workers beyond the active range.
		set_workers(5'd4);
		add_event(llwd_pkg::ACT_SERVED,   16'h0000, 4'd0,  4'd9);
		add_event(llwd_pkg::ACT_SERVED,   16'h0000, 4'd0,  4'd4);
		add_event(llwd_pkg::ACT_SERVED,   16'h0000, 4'd0,  4'd8);
		add_event(llwd_pkg::ACT_DISPATCH, 16'hC3C3, 4'd12, 4'd0);
		add_event(llwd_pkg::ACT_DISPATCH, 16'h3C3C, 4'd4,  4'd0);
		add_event(llwd_pkg::ACT_DISPATCH, 16'h0F0F, 4'd3,  4'd0);
		add_event(llwd_pkg::ACT_SERVED,   16'h0000, 4'd0,  4'd3);
		add_event(llwd_pkg::ACT_SERVED,   16'h0000, 4'd0,  4'd3);
		add_random(120);

		set_workers(5'd0);
		add_random(60);

		send_idle_pct = 80;
		recv_idle_pct = 31;
		set_workers(5'd31);
		add_random(120);
		set_workers(5'd17);
		add_random(60);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_workers(5'd9);
		add_random(150);
		hold_req = 1'b1;
		set_workers(5'd16);
		add_random(100);

		// A single worker takes every dispatch, then served events bring it down.
		set_workers(5'd1);
		repeat (60)
			add_event(llwd_pkg::ACT_DISPATCH, 16'($urandom), 4'($urandom), 4'($urandom));
		add_event(llwd_pkg::ACT_SERVED,   16'h0000, 4'd0, 4'd0);
		add_event(llwd_pkg::ACT_SERVED,   16'h0000, 4'd0, 4'd1);
		add_event(llwd_pkg::ACT_DISPATCH, 16'hFEED, 4'd5, 4'd0);
		add_event(llwd_pkg::ACT_DISPATCH, 16'hBEEF, 4'd0, 4'd0);
		add_event(llwd_pkg::ACT_SERVED,   16'h0000, 4'd0, 4'd0);

		settle();
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
